// ----- src/itoa_fmt_pkg.sv -----
// Package with shared constants, types and the digit-to-ASCII function of the formatter.
`default_nettype none
package itoa_fmt_pkg;

  // Default width of the converted word.
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Mode codes as presented on the mode input.
  localparam logic [1:0] MODE_DEC    = 2'd0;
  localparam logic [1:0] MODE_HEX_LO = 2'd1;
  localparam logic [1:0] MODE_HEX_UP = 2'd2;

  // ASCII codes used by the formatter.
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_LO_A  = 8'h61;
  localparam logic [7:0] ASCII_UP_A  = 8'h41;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_e;

  // Map one digit to its ASCII code; any mode other than decimal or
  // lowercase hex prints uppercase letters.
  function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic [1:0] mode);
    logic [7:0] letter_base;
    letter_base = (mode == MODE_HEX_LO) ? ASCII_LO_A : ASCII_UP_A;
    if (digit < 4'd10) begin
      digit_char = ASCII_ZERO + {4'd0, digit};
    end else begin
      digit_char = letter_base + {4'd0, digit - 4'd10};
    end
  endfunction

endpackage
`default_nettype wire

// ----- src/integer_to_ascii_formatter_unit.sv -----
// Bit-serial integer to ASCII formatter: signed decimal, lowercase or uppercase hex.
// Steps: decimal runs one double-dabble step per input bit, then an optional sign
// step, then a scan over NUM_DIGITS digits; hex goes straight to the scan. Each digit
// is registered to the output in the cycle after the scan reaches it, once leading
// zeros are past. The next request is taken in the cycle the last character leaves,
// so a request is not taken before the previous one is through; the receiver cannot
// stall characters.
// rst_ni clears the controller and the output strobe.
`default_nettype none
module integer_to_ascii_formatter_unit #(
  parameter int unsigned VALUE_WIDTH = itoa_fmt_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire logic [1:0]             mode_i,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  output logic                        valid_o,
  output logic [7:0]                  character_o,
  output logic                        last_o,
  output logic [3:0]                  char_count_o
);

  // Decimal digits needed for VALUE_WIDTH bits; hex needs fewer.
  localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned DIG_W      = 4 * NUM_DIGITS;
  localparam int unsigned IDX_W      = $clog2(NUM_DIGITS);
  localparam int unsigned BIT_W      = $clog2(VALUE_WIDTH);

  itoa_fmt_pkg::state_e state_q, state_d;

  logic [1:0]             mode_q, mode_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [DIG_W-1:0]       dig_q, dig_d;
  logic [BIT_W-1:0]       bit_q, bit_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   started_q, started_d;
  logic [3:0]             cnt_q, cnt_d;

  logic                   valid_q, valid_d;
  logic [7:0]             char_q, char_d;
  logic                   last_q, last_d;
  logic [3:0]             count_q, count_d;

  logic                   accept;
  logic                   conv_done;
  logic [3:0]             top_digit;
  logic                   emit_now;
  logic                   scan_end;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic [DIG_W-1:0]       dig_adj;

  assign accept    = start_i && (state_q == itoa_fmt_pkg::ST_IDLE);
  assign conv_done = (bit_q == BIT_W'(VALUE_WIDTH - 1));
  assign top_digit = dig_q[DIG_W-1 -: 4];
  assign scan_end  = (idx_q == '0);
  assign emit_now  = started_q || (top_digit != 4'd0) || scan_end;
  assign magnitude = value_i[VALUE_WIDTH-1] ? (~value_i + VALUE_WIDTH'(1)) : value_i;

  // Double-dabble correction: add three to every BCD digit of five or more.
  always_comb begin
    dig_adj = dig_q;
    for (int i = 0; i < int'(NUM_DIGITS); i++) begin
      if (dig_q[4*i +: 4] >= 4'd5) begin
        dig_adj[4*i +: 4] = dig_q[4*i +: 4] + 4'd3;
      end
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itoa_fmt_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = (mode_i == itoa_fmt_pkg::MODE_DEC) ? itoa_fmt_pkg::ST_CONV
                                                       : itoa_fmt_pkg::ST_EMIT;
        end
      end
      itoa_fmt_pkg::ST_CONV: begin
        if (conv_done) begin
          state_d = neg_q ? itoa_fmt_pkg::ST_SIGN : itoa_fmt_pkg::ST_EMIT;
        end
      end
      itoa_fmt_pkg::ST_SIGN: begin
        state_d = itoa_fmt_pkg::ST_EMIT;
      end
      itoa_fmt_pkg::ST_EMIT: begin
        if (scan_end) begin
          state_d = itoa_fmt_pkg::ST_IDLE;
        end
      end
      default: state_d = itoa_fmt_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    mode_d    = mode_q;
    neg_d     = neg_q;
    bin_d     = bin_q;
    dig_d     = dig_q;
    bit_d     = bit_q;
    idx_d     = idx_q;
    started_d = started_q;
    cnt_d     = cnt_q;
    valid_d   = 1'b0;
    char_d    = char_q;
    last_d    = last_q;
    count_d   = count_q;
    unique case (state_q)
      itoa_fmt_pkg::ST_IDLE: begin
        if (start_i) begin
          mode_d    = mode_i;
          bit_d     = '0;
          idx_d     = IDX_W'(NUM_DIGITS - 1);
          started_d = 1'b0;
          cnt_d     = 4'd0;
          if (mode_i == itoa_fmt_pkg::MODE_DEC) begin
            neg_d = value_i[VALUE_WIDTH-1];
            bin_d = magnitude;
            dig_d = '0;
          end else begin
            neg_d = 1'b0;
            dig_d = {{(DIG_W - VALUE_WIDTH){1'b0}}, value_i};
          end
        end
      end
      itoa_fmt_pkg::ST_CONV: begin
        // Shift one magnitude bit into the corrected BCD register.
        dig_d = {dig_adj[DIG_W-2:0], bin_q[VALUE_WIDTH-1]};
        bin_d = {bin_q[VALUE_WIDTH-2:0], 1'b0};
        bit_d = bit_q + BIT_W'(1);
      end
      itoa_fmt_pkg::ST_SIGN: begin
        valid_d = 1'b1;
        char_d  = itoa_fmt_pkg::ASCII_MINUS;
        last_d  = 1'b0;
        count_d = 4'd0;
        cnt_d   = 4'd1;
      end
      itoa_fmt_pkg::ST_EMIT: begin
        // Scan digits from the top, skipping leading zeros.
        dig_d = {dig_q[DIG_W-5:0], 4'd0};
        idx_d = idx_q - IDX_W'(1);
        if (emit_now) begin
          started_d = 1'b1;
          cnt_d     = cnt_q + 4'd1;
          valid_d   = 1'b1;
          char_d    = itoa_fmt_pkg::digit_char(top_digit, mode_q);
          last_d    = scan_end;
          count_d   = scan_end ? (cnt_q + 4'd1) : 4'd0;
        end
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_fmt_pkg::ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    neg_q     <= neg_d;
    bin_q     <= bin_d;
    dig_q     <= dig_d;
    bit_q     <= bit_d;
    idx_q     <= idx_d;
    started_q <= started_d;
    cnt_q     <= cnt_d;
    char_q    <= char_d;
    last_q    <= last_d;
    count_q   <= count_d;
  end

  assign busy_o       = (state_q != itoa_fmt_pkg::ST_IDLE);
  assign valid_o      = valid_q;
  assign character_o  = char_q;
  assign last_o       = last_q && valid_q;
  assign char_count_o = valid_q ? count_q : 4'd0;

  // An accepted request makes the unit busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("request accepted but unit not busy");

  // A character that is not the last one is always followed by more work.
  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> busy_o) else $error("string ended without a last flag");

  // The count is only shown on the last character.
  a_count_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> (char_count_o == 4'd0)) else $error("count on inner character");

  // A sign character only leaves right after decimal conversion finished.
  a_sign_after_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == itoa_fmt_pkg::ST_SIGN) |-> ($past(state_q) == itoa_fmt_pkg::ST_CONV))
    else $error("sign state entered out of order");

endmodule
`default_nettype wire
